// ----- src/edt_pkg.sv -----
// Shared types and constants for the escaped delimiter tokenizer.
package edt_pkg;

  localparam int DELIM_MAX  = 8;
  localparam int HOLD_DEPTH = DELIM_MAX + 1;
  localparam int CHAR_W     = 8;
  localparam int CNT_W      = 4;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_CHARS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CHAR = 3'd3;

  localparam logic            KIND_CHAR = 1'b0;
  localparam logic            KIND_END  = 1'b1;
  localparam logic [CHAR_W-1:0] NUL_CHAR = 8'h00;

  typedef struct packed {
    logic                        set_mode;
    logic [CNT_W-1:0]            delim_len;
    logic [DELIM_MAX*CHAR_W-1:0] delim_chars;
    logic [CHAR_W-1:0]           escape_char;
  } cfg_t;

  // One queued job: the window (position 0 = newest), which positions to
  // emit as token text (oldest first), and whether an end marker follows.
  typedef struct packed {
    logic [HOLD_DEPTH-1:0][CHAR_W-1:0] win;
    logic [HOLD_DEPTH-1:0]             mask;
    logic                              tok_end;
  } cmd_t;

endpackage

// ----- src/escaped_delimiter_tokenizer_top.sv -----
// Top level of the escaped delimiter tokenizer: config registers and wiring.
//
// Usage:
//   Input channel (in_valid/in_ready): one character per beat; in_last_char
//   marks the final character of a string and flushes everything held.
//   Output channel (out_valid/out_ready): one result per beat, either a token
//   character (out_kind 0, out_char) or a token-end marker (out_kind 1).
//   out_run_last is high on the final beat caused by one input character.
//   Config channel (cfg_valid/cfg_ready): always ready; write set_mode,
//   delim_len, delim_chars and escape_char by index 0..3, only while idle.
// Timing:
//   The front end takes one character per cycle whenever the job queue has
//   room. A character that yields k results gives k output beats; the
//   emitter is the only multi-cycle unit. With an idle emitter a job passes
//   the queue register, then the emitter registers, before out_valid rises.
// Stall and reset:
//   When the receiver stalls, the emitter holds its beat and the four-entry
//   queue absorbs further jobs; in_ready drops only when the queue is full.
//   Reset clears the held count, the open-token flag, the queue and the
//   emitter, and loads the config reset values (set mode, one space).
module escaped_delimiter_tokenizer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [edt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [edt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [edt_pkg::CHAR_W-1:0]      in_char,
  input  logic                            in_last_char,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_kind,
  output logic [edt_pkg::CHAR_W-1:0]      out_char,
  output logic                            out_run_last
);
  import edt_pkg::*;

  cfg_t cfg_r;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_not_full;
  logic q_pop;
  logic q_not_empty;
  cmd_t q_pop_cmd;

  // Config writes are registered; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_mode    <= 1'b1;
      cfg_r.delim_len   <= CNT_W'(1);
      cfg_r.delim_chars <= (DELIM_MAX*CHAR_W)'(32);
      cfg_r.escape_char <= NUL_CHAR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SET_MODE:    cfg_r.set_mode    <= cfg_data[0];
        CFG_DELIM_LEN:   cfg_r.delim_len   <= cfg_data[CNT_W-1:0];
        CFG_DELIM_CHARS: cfg_r.delim_chars <= cfg_data[DELIM_MAX*CHAR_W-1:0];
        CFG_ESCAPE_CHAR: cfg_r.escape_char <= cfg_data[CHAR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: match the window, decide which held characters to release.
  edt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .in_last_char (in_last_char),
    .q_ready      (q_not_full),
    .q_push       (q_push),
    .q_cmd        (q_push_cmd)
  );

  // Decouple the front end from output stalls.
  edt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_cmd   (q_pop_cmd)
  );

  // Back end: serialize each job into result beats.
  edt_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_not_empty),
    .q_cmd        (q_pop_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

endmodule

// ----- src/edt_front.sv -----
// Front end: holds candidate characters, matches delimiters, builds emit jobs.
module edt_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  edt_pkg::cfg_t               cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [edt_pkg::CHAR_W-1:0]  in_char,
  input  logic                        in_last_char,
  input  logic                        q_ready,
  output logic                        q_push,
  output edt_pkg::cmd_t               q_cmd
);
  import edt_pkg::*;

  logic [DELIM_MAX-1:0][CHAR_W-1:0]  hold_r, hold_nxt;
  logic [CNT_W-1:0]                  hold_cnt_r, hold_cnt_nxt;
  logic                              open_r, open_nxt;

  logic [HOLD_DEPTH-1:0][CHAR_W-1:0] win;
  logic [DELIM_MAX-1:0][CHAR_W-1:0]  delim;
  logic [CNT_W-1:0]                  clip_len;
  logic [CNT_W-1:0]                  m;
  logic [2:0]                        m_idx;
  logic [CNT_W-1:0]                  cnt;
  logic [DELIM_MAX-1:0]              str_hit;
  logic                              set_hit;
  logic                              tail_ok;
  logic                              esc;
  logic [HOLD_DEPTH-1:0]             vmask;
  logic [HOLD_DEPTH-1:0]             older;
  logic [HOLD_DEPTH-1:0]             not_m;
  logic [HOLD_DEPTH-1:0]             mask;
  logic                              end_req;
  logic                              any_char;
  logic                              tok_end;
  logic                              accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;

  always_comb begin
    for (int k = 0; k < DELIM_MAX; k++) begin
      delim[k] = cfg.delim_chars[k*CHAR_W +: CHAR_W];
    end
    win[0] = in_char;
    for (int k = 1; k < HOLD_DEPTH; k++) begin
      win[k] = hold_r[k-1];
    end

    if (cfg.delim_len == '0) begin
      clip_len = CNT_W'(1);
    end else if (cfg.delim_len > CNT_W'(DELIM_MAX)) begin
      clip_len = CNT_W'(DELIM_MAX);
    end else begin
      clip_len = cfg.delim_len;
    end
    m     = cfg.set_mode ? CNT_W'(1) : clip_len;
    m_idx = 3'(m - CNT_W'(1));
    cnt   = hold_cnt_r + CNT_W'(1);

    set_hit = 1'b0;
    for (int k = 0; k < DELIM_MAX; k++) begin
      if (CNT_W'(k) < clip_len && delim[k] == in_char) begin
        set_hit = 1'b1;
      end
    end

    // One comparator row per delimiter length: delimiter byte j sits at
    // window position len-1-j.
    for (int l = 0; l < DELIM_MAX; l++) begin
      str_hit[l] = 1'b1;
      for (int j = 0; j <= l; j++) begin
        if (win[l-j] != delim[j]) begin
          str_hit[l] = 1'b0;
        end
      end
    end

    tail_ok = (cnt >= m) && (cfg.set_mode ? set_hit : str_hit[m_idx]);
    esc     = (cfg.escape_char != NUL_CHAR) && (cnt > m) && (win[m] == cfg.escape_char);

    for (int k = 0; k < HOLD_DEPTH; k++) begin
      vmask[k] = CNT_W'(k) < cnt;
      older[k] = CNT_W'(k) >= m;
      not_m[k] = CNT_W'(k) != m;
    end

    end_req = 1'b0;
    if (tail_ok) begin
      hold_cnt_nxt = '0;
      if (esc) begin
        mask = vmask & not_m;
      end else begin
        mask    = vmask & older;
        end_req = 1'b1;
      end
    end else begin
      mask         = vmask & older;
      hold_cnt_nxt = (cnt < m) ? cnt : m;
    end
    if (in_last_char) begin
      if (!tail_ok) begin
        mask = vmask;
      end
      hold_cnt_nxt = '0;
      end_req      = 1'b1;
    end

    any_char = |mask;
    tok_end  = end_req && (open_r || any_char);
    open_nxt = end_req ? 1'b0 : (open_r || any_char);

    for (int k = 0; k < DELIM_MAX; k++) begin
      hold_nxt[k] = win[k];
    end
  end

  assign q_cmd.win     = win;
  assign q_cmd.mask    = mask;
  assign q_cmd.tok_end = tok_end;
  assign q_push        = accept && (any_char || tok_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt_r <= '0;
      open_r     <= 1'b0;
    end else if (accept) begin
      hold_cnt_r <= hold_cnt_nxt;
      open_r     <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r <= hold_nxt;
    end
  end

endmodule

// ----- src/edt_queue.sv -----
// Short job queue between the front end and the emitter.
module edt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  edt_pkg::cmd_t push_cmd,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output edt_pkg::cmd_t pop_cmd
);
  import edt_pkg::*;

  cmd_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic               do_push;
  logic               do_pop;

  assign not_full  = count_r != Q_CNT_W'(Q_DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- src/edt_back.sv -----
// Emitter: walks one job, one result beat per cycle while out_ready is high, oldest character first.
module edt_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  edt_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_kind,
  output logic [edt_pkg::CHAR_W-1:0]  out_char,
  output logic                        out_run_last
);
  import edt_pkg::*;

  logic [HOLD_DEPTH-1:0][CHAR_W-1:0] win_r;
  logic [HOLD_DEPTH-1:0]             mask_r;
  logic                              end_r;
  logic [HOLD_DEPTH-1:0]             mask_after;
  logic [CNT_W-1:0]                  sel;
  logic                              has_char;
  logic                              fire;
  logic                              done;

  always_comb begin
    sel = '0;
    for (int k = 0; k < HOLD_DEPTH; k++) begin
      if (mask_r[k]) begin
        sel = CNT_W'(k);
      end
    end
    for (int k = 0; k < HOLD_DEPTH; k++) begin
      mask_after[k] = mask_r[k] && (CNT_W'(k) != sel);
    end
  end

  assign has_char     = |mask_r;
  assign out_valid    = has_char || end_r;
  assign out_kind     = has_char ? KIND_CHAR : KIND_END;
  assign out_char     = has_char ? win_r[sel] : NUL_CHAR;
  assign out_run_last = has_char ? ((mask_after == '0) && !end_r) : 1'b1;
  assign fire         = out_valid && out_ready;
  assign done         = !out_valid || (fire && out_run_last);
  assign q_pop        = done && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
      end_r  <= 1'b0;
    end else if (q_pop) begin
      mask_r <= q_cmd.mask;
      end_r  <= q_cmd.tok_end;
    end else if (fire) begin
      if (has_char) begin
        mask_r <= mask_after;
      end else begin
        end_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      win_r <= q_cmd.win;
    end
  end

endmodule

// ----- dv/escaped_delimiter_tokenizer_top_test.sv -----
// Self-checking testbench for the escaped delimiter tokenizer top level.
`timescale 1ns / 1ps

module escaped_delimiter_tokenizer_top_test;
  import edt_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SETTLE_CYCLES = 12;    // covers the queue and the emitter registers
  localparam int MAX_SHOWN     = 10;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 50;

  // Any index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  // One result beat as the output channel shows it.
  typedef struct packed {
    logic              kind;
    logic [CHAR_W-1:0] ch;
    logic              run_last;
  } tok_beat_t;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_COIN, RX_PULSE} rx_pat_t;
  typedef enum {PC_DELIM, PC_PARTIAL, PC_ESC_DELIM, PC_ESC, PC_TEXT, PC_NOISE} piece_t;

  // Mirror of the splitter: register copies, held characters and the open-token flag.
  // take_char() works out the beats one character causes; match_beat() checks them.
  class token_splitter;
    logic                  set_mode;
    logic [CNT_W-1:0]      delim_len;
    logic [CFG_DATA_W-1:0] delim_chars;
    logic [CHAR_W-1:0]     esc_char;
    logic [CHAR_W-1:0]     held[HOLD_DEPTH];
    int                    held_n;
    logic                  tok_open;
    tok_beat_t             due_beats[$];
    int                    n_fail;
    int                    n_chars;
    int                    n_beats;
    int                    n_ends;

    function new();
      set_mode    = 1'b1;
      delim_len   = 4'd1;
      delim_chars = 64'h20;   // a single space
      esc_char    = NUL_CHAR;
      held_n      = 0;
      tok_open    = 1'b0;
      n_fail      = 0;
      n_chars     = 0;
      n_beats     = 0;
      n_ends      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SET_MODE:    set_mode    = val[0];
        CFG_DELIM_LEN:   delim_len   = val[CNT_W-1:0];
        CFG_DELIM_CHARS: delim_chars = val;
        CFG_ESCAPE_CHAR: esc_char    = val[CHAR_W-1:0];
        default: ;
      endcase
    endfunction

    function int clip_len();
      if (delim_len == 0) return 1;
      if (delim_len > DELIM_MAX) return DELIM_MAX;
      return int'(delim_len);
    endfunction

    function logic [CHAR_W-1:0] delim_at(int k);
      return delim_chars[CHAR_W*k +: CHAR_W];
    endfunction

    function bit tail_hit(int m);
      logic [CHAR_W-1:0] c;
      if (set_mode) begin
        c = held[held_n-1];
        for (int k = 0; k < clip_len(); k++)
          if (delim_at(k) == c) return 1'b1;
        return 1'b0;
      end
      for (int k = 0; k < m; k++)
        if (held[held_n-m+k] != delim_at(k)) return 1'b0;
      return 1'b1;
    endfunction

    // Append one beat at the tail of the expected list.
    function void add_beat(tok_beat_t b);
      due_beats.insert(due_beats.size(), b);
    endfunction

    function void push_char(logic [CHAR_W-1:0] ch);
      add_beat('{KIND_CHAR, ch, 1'b0});
      tok_open = 1'b1;
    endfunction

    function void close_token();
      if (tok_open) add_beat('{KIND_END, NUL_CHAR, 1'b0});
      tok_open = 1'b0;
    endfunction

    function void emit_oldest();
      push_char(held[0]);
      for (int k = 0; k + 1 < held_n; k++) held[k] = held[k+1];
      held_n--;
    endfunction

    function void take_char(logic [CHAR_W-1:0] c, logic last);
      int        m;
      int        start;
      int        n0;
      bit        esc_hit;
      tok_beat_t b;
      m  = set_mode ? 1 : clip_len();
      n0 = due_beats.size();
      n_chars++;
      while (held_n >= HOLD_DEPTH) emit_oldest();
      held[held_n] = c;
      held_n++;
      if (held_n >= m && tail_hit(m)) begin
        start   = held_n - m;
        esc_hit = esc_char != NUL_CHAR && held_n > m && held[start-1] == esc_char;
        if (esc_hit) begin
          // drop the escape byte, keep the delimiter as text
          for (int i = 0; i + 1 < start; i++) push_char(held[i]);
          for (int i = start; i < held_n; i++) push_char(held[i]);
        end else begin
          for (int i = 0; i < start; i++) push_char(held[i]);
          close_token();
        end
        held_n = 0;
      end else begin
        while (held_n > m) emit_oldest();
      end
      if (last) begin
        for (int i = 0; i < held_n; i++) push_char(held[i]);
        held_n = 0;
        close_token();
      end
      if (due_beats.size() > n0) begin
        b          = due_beats[due_beats.size()-1];
        b.run_last = 1'b1;
        due_beats[due_beats.size()-1] = b;
      end
    endfunction

    function void flag(string msg);
      n_fail++;
      if (n_fail <= MAX_SHOWN) $display("MISMATCH: %s", msg);
    endfunction

    function void match_beat(logic kind, logic [CHAR_W-1:0] ch, logic run_last);
      tok_beat_t e;
      n_beats++;
      if (kind === KIND_END) n_ends++;
      if (due_beats.size() == 0) begin
        flag($sformatf("beat %0d not expected: kind=%0b char=%02h run_last=%0b",
                       n_beats, kind, ch, run_last));
        return;
      end
      e = due_beats.pop_front();
      if (e.kind !== kind || e.ch !== ch || e.run_last !== run_last)
        flag($sformatf("beat %0d: expected kind=%0b char=%02h run_last=%0b, got %0b %02h %0b",
                       n_beats, e.kind, e.ch, e.run_last, kind, ch, run_last));
    endfunction

    function void flag_leftover();
      if (due_beats.size() != 0)
        flag($sformatf("%0d expected beats never arrived", due_beats.size()));
    endfunction
  endclass

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = CFG_SET_MODE;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_char      = NUL_CHAR;
  logic                  in_last_char = 1'b0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic                  out_kind;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_run_last;

  token_splitter tok_chk = new();

  // Stimulus-side copy of the settings, used only to shape the character stream.
  logic                  cur_set   = 1'b1;
  int                    cur_eff   = 1;
  logic [CFG_DATA_W-1:0] cur_chars = 64'h20;
  logic [CHAR_W-1:0]     cur_esc   = NUL_CHAR;

  int      items_sent = 0;
  int      n_settings = 0;
  int      burst_left = 0;
  bit      idle_on    = 1'b1;
  int      cycle_cnt  = 0;
  rx_pat_t rx_pat     = RX_OPEN;
  int      rx_span    = 0;

  escaped_delimiter_tokenizer_top u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char      (in_char),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .out_char     (out_char),
    .out_run_last (out_run_last)
  );

  always #5 clk = ~clk;

  // Watch all three channels at the edge; every handshake here uses pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) tok_chk.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) tok_chk.take_char(in_char, in_last_char);
      if (out_valid && out_ready) tok_chk.match_beat(out_kind, out_char, out_run_last);
    end
  end

  // Receiver: switch between stall patterns, each held for a random span.
  // RX_OPEN gives stretches with no back-pressure at all; RX_PULSE gives long stalls.
  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_pat  <= rx_pat_t'($urandom_range(0, 3));
      rx_span <= $urandom_range(16, 200);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_pat)
      RX_OPEN:   out_ready <= 1'b1;
      RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      RX_COIN:   out_ready <= ($urandom_range(0, 1) == 0);
      default:   out_ready <= ((rx_span % 9) < 2);
    endcase
  end

  // Watchdog: bail out if the run hangs.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d beats still due",
               cycle_cnt, tok_chk.due_beats.size());
      $display("escaped_delimiter_tokenizer_top_test NOT OK");
      $finish;
    end
  end

  // Present one character and hold it until the block takes the beat. Valid stays
  // high into the next beat unless a gap between bursts drops it first.
  task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
    int gap;
    if (idle_on && burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char      <= c;
    in_last_char <= last;
    do @(posedge clk); while (!(in_valid && in_ready));
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic last_on_end);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], last_on_end && i == s.len() - 1);
  endtask

  // Drop valid, wait until every due beat has arrived, then hold off long enough
  // for jobs that produce no beat to leave the queue. Poll on the falling edge so
  // the monitor has already run for this cycle.
  task automatic settle();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (tok_chk.due_beats.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four registers back to back, optionally followed by a write to an
  // unused index. Upper data bits carry noise that the block must ignore.
  task automatic apply_config(input logic sm, input logic [CNT_W-1:0] len,
                              input logic [CFG_DATA_W-1:0] chars,
                              input logic [CHAR_W-1:0] esc, input logic spare);
    logic [CFG_IDX_W-1:0]  idx[5];
    logic [CFG_DATA_W-1:0] val[5];
    logic [CFG_DATA_W-1:0] junk;
    int                    n;
    junk   = {$urandom, $urandom};
    idx[0] = CFG_SET_MODE;    val[0] = {junk[63:1], sm};
    idx[1] = CFG_DELIM_LEN;   val[1] = {junk[63:CNT_W], len};
    idx[2] = CFG_DELIM_CHARS; val[2] = chars;
    idx[3] = CFG_ESCAPE_CHAR; val[3] = {junk[63:CHAR_W], esc};
    idx[4] = CFG_IDX_SPARE;   val[4] = ~junk;
    n = spare ? 5 : 4;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
    end
    cfg_valid <= 1'b0;
    cur_set   = sm;
    cur_eff   = (len == 0) ? 1 : ((len > DELIM_MAX) ? DELIM_MAX : len);
    cur_chars = chars;
    cur_esc   = esc;
    n_settings++;
  endtask

  // Bytes for delimiter strings: a tiny alphabet so text and delimiters collide.
  function automatic logic [CHAR_W-1:0] alpha_byte();
    case ($urandom_range(0, 4))
      0:       return "a";
      1:       return "b";
      2:       return "/";
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Text that often looks like part of a delimiter, including unused slots.
  function automatic logic [CHAR_W-1:0] pick_text();
    if ($urandom_range(0, 3) == 0) return CHAR_W'("x" + $urandom_range(0, 2));
    return cur_chars[CHAR_W*$urandom_range(0, DELIM_MAX-1) +: CHAR_W];
  endfunction

  // Send one piece of a stream: mostly delimiters, near-misses and escapes with
  // random content around them, plus some raw noise. Any byte may end the string.
  task automatic send_piece();
    logic [CHAR_W-1:0] seq[$];
    piece_t            pc;
    int                r;
    int                n;
    r  = $urandom_range(0, 99);
    pc = (r < 25) ? PC_DELIM : (r < 40) ? PC_PARTIAL : (r < 55) ? PC_ESC_DELIM :
         (r < 60) ? PC_ESC : (r < 90) ? PC_TEXT : PC_NOISE;
    if (pc == PC_ESC || pc == PC_ESC_DELIM) seq.insert(seq.size(), cur_esc);
    case (pc)
      PC_DELIM, PC_ESC_DELIM: begin
        if (cur_set) begin
          seq.insert(seq.size(), cur_chars[CHAR_W*$urandom_range(0, cur_eff-1) +: CHAR_W]);
        end else begin
          for (int k = 0; k < cur_eff; k++)
            seq.insert(seq.size(), cur_chars[CHAR_W*k +: CHAR_W]);
        end
      end
      PC_PARTIAL: begin
        if (cur_set || cur_eff < 2) begin
          seq.insert(seq.size(), pick_text());
        end else begin
          n = $urandom_range(1, cur_eff - 1);
          for (int k = 0; k < n; k++) seq.insert(seq.size(), cur_chars[CHAR_W*k +: CHAR_W]);
        end
      end
      PC_TEXT: begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) seq.insert(seq.size(), pick_text());
      end
      PC_NOISE: seq.insert(seq.size(), CHAR_W'($urandom_range(0, 255)));
      default: ;
    endcase
    foreach (seq[i]) send_char(seq[i], $urandom_range(0, 24) == 0);
  endtask

  // One random phase: fresh settings, a stream, one pause mid-way until the block
  // drains, and sometimes no closing flush so characters stay held into the next
  // setting.
  task automatic run_phase(input int idx, input int n_items);
    logic                  sm;
    logic [CNT_W-1:0]      len;
    logic [CFG_DATA_W-1:0] chars;
    logic [CHAR_W-1:0]     esc;
    int                    first;
    int                    pause_at;
    sm = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0:       len = 4'd0;
      1:       len = CNT_W'(DELIM_MAX);
      2:       len = CNT_W'($urandom_range(DELIM_MAX + 1, 15));
      default: len = CNT_W'($urandom_range(1, 3));
    endcase
    for (int k = 0; k < DELIM_MAX; k++) chars[CHAR_W*k +: CHAR_W] = alpha_byte();
    case ($urandom_range(0, 4))
      0:       esc = NUL_CHAR;
      1:       esc = "\\";
      2:       esc = 8'hFF;
      3:       esc = alpha_byte();
      default: esc = CHAR_W'($urandom_range(1, 255));
    endcase
    // pin the length extremes on the first two phases
    if (idx == 0) begin
      sm    = 1'b0;
      len   = 4'd15;
      chars = {$urandom, $urandom};
    end
    if (idx == 1) begin
      sm  = 1'b1;
      len = CNT_W'(DELIM_MAX);
    end
    apply_config(sm, len, chars, esc, idx == 4);
    idle_on  = (idx % 3) != 2;
    first    = items_sent;
    pause_at = first + $urandom_range(10, n_items - 10);
    while (items_sent - first < n_items) begin
      if (pause_at >= 0 && items_sent >= pause_at) begin
        settle();
        pause_at = -1;
      end
      send_piece();
    end
    if ($urandom_range(0, 1) == 0) send_char(pick_text(), 1'b1);
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: split on space. Leading, doubled and trailing delimiters
    // must not make empty tokens.
    send_text(" a  b ", 1'b1);
    settle();

    // String mode on "ab" with a backslash escape: escaped delimiter kept as
    // text, an escaped match right after another, and an escape at end of stream.
    apply_config(1'b0, 4'd2, 64'h6261, "\\", 1'b1);
    send_text("x\\abyab", 1'b0);
    send_text("\\abab", 1'b0);
    send_text("z\\", 1'b1);
    settle();

    // Set mode with length zero (acts as one comma), escape 0xFF, NUL as text.
    apply_config(1'b1, 4'd0, 64'hFFFF_FFFF_FFFF_FF2C, 8'hFF, 1'b0);
    send_char(NUL_CHAR, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(",", 1'b0);
    send_char("b", 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(",", 1'b1);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) run_phase(p, PHASE_ITEMS);

    tok_chk.flag_leftover();
    $display("Covered %0d characters and %0d result beats (%0d token ends) over %0d settings,",
             tok_chk.n_chars, tok_chk.n_beats, tok_chk.n_ends, n_settings);
    $display("with set and string modes, escapes, flushes and receiver stalls; %0d failures",
             tok_chk.n_fail);
    if (tok_chk.n_fail == 0) begin
      $display("escaped_delimiter_tokenizer_top_test OK");
    end else begin
      $display("escaped_delimiter_tokenizer_top_test NOT OK");
    end
    $finish;
  end

endmodule
